### rtl/core/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants of the interval proximity clusterer.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CHROM_W     = 10;
	localparam int POS_W       = 31;
	localparam int CLU_W       = 12;
	localparam int SIZE_W      = 13;

	localparam logic [POS_W-1:0] TOL_RESET  = POS_W'(50);
	localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(MAX_ENTRIES);

	typedef struct packed {
		logic               set_begin;
		logic [CHROM_W-1:0] chrom_id;
		logic [POS_W-1:0]   start_pos;
		logic [POS_W-1:0]   end_pos;
	} in_item_t;

	typedef struct packed {
		logic [CLU_W-1:0]  cluster_index;
		logic              opened_new;
		logic [SIZE_W-1:0] cluster_size;
		logic              table_full;
	} out_item_t;

	typedef struct packed {
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0]   start_pos;
		logic [POS_W-1:0]   end_pos;
		logic [CLU_W-1:0]   cluster;
	} member_t;

	typedef struct packed {
		logic              scan_start;
		logic [CNT_W-1:0]  scan_len;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		member_t           wr_data;
	} match_cmd_t;

	typedef struct packed {
		logic             idle;
		logic             found;
		logic [CLU_W-1:0] best;
	} match_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_CNT_RD,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

### rtl/core/ipc_match.sv
// ----------------------------------------------------------------------------
// ipc_match
// Member table and the shared compare unit: one stored member per cycle is
// read, checked against the key and folded into the lowest matching cluster.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_match (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ipc_pkg::match_cmd_t           cmd,
	input  wire ipc_pkg::in_item_t             key,
	input  wire logic [ipc_pkg::POS_W-1:0]     tol,
	output ipc_pkg::match_sts_t                sts
);

	ipc_pkg::member_t mem_q [ipc_pkg::MAX_ENTRIES];

	logic [ipc_pkg::CNT_W-1:0]   scan_q;
	logic [ipc_pkg::CNT_W-1:0]   len_q;
	logic                        active_q;
	logic                        v_s1;
	logic                        v_s2;
	ipc_pkg::member_t            rd_s1;
	logic                        eq_s2;
	logic [ipc_pkg::POS_W-1:0]   ds_s2;
	logic [ipc_pkg::POS_W-1:0]   de_s2;
	logic [ipc_pkg::CLU_W-1:0]   clu_s2;
	logic                        found_q;
	logic [ipc_pkg::CLU_W-1:0]   best_q;
	logic [ipc_pkg::CNT_W-1:0]   scan_nxt;
	logic                        hit;

	assign scan_nxt = scan_q + ipc_pkg::CNT_W'(1);
	assign hit      = v_s2 && eq_s2 && (ds_s2 <= tol) && (de_s2 <= tol);

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= cmd.wr_data;
		end
		rd_s1 <= mem_q[scan_q[ipc_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		eq_s2  <= (rd_s1.chrom == key.chrom_id);
		ds_s2  <= (key.start_pos >= rd_s1.start_pos) ? key.start_pos - rd_s1.start_pos
		                                             : rd_s1.start_pos - key.start_pos;
		de_s2  <= (key.end_pos >= rd_s1.end_pos) ? key.end_pos - rd_s1.end_pos
		                                         : rd_s1.end_pos - key.end_pos;
		clu_s2 <= rd_s1.cluster;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			len_q    <= '0;
			active_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			found_q  <= 1'b0;
			best_q   <= '0;
		end else begin
			v_s1 <= active_q;
			v_s2 <= v_s1;
			if (cmd.scan_start) begin
				scan_q   <= '0;
				len_q    <= cmd.scan_len;
				active_q <= (cmd.scan_len != '0);
				found_q  <= 1'b0;
			end else if (active_q) begin
				scan_q <= scan_nxt;
				if (scan_nxt == len_q) begin
					active_q <= 1'b0;
				end
			end
			if (hit && (!found_q || clu_s2 < best_q)) begin
				found_q <= 1'b1;
				best_q  <= clu_s2;
			end
		end
	end

	assign sts.idle  = !active_q && !v_s1 && !v_s2;
	assign sts.found = found_q;
	assign sts.best  = best_q;

endmodule

`default_nettype wire

### rtl/core/interval_proximity_clusterer.sv
// ----------------------------------------------------------------------------
// interval_proximity_clusterer
// Assigns junction records to proximity clusters of stored members.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry set_begin, chrom_id, start_pos and
// end_pos. Each beat yields exactly one output beat (out_valid/out_ready)
// with cluster_index, opened_new, cluster_size and table_full.
// in_ready is high only while the sequencer is idle. An accepted beat scans
// every stored member through one compare unit, one member per cycle from
// the member memory. With N members stored before it (up to 4096 once the
// table fills), all N pass the compare unit, then the cluster count is read
// and the result is registered; the next input beat can be taken the cycle after.
// The result lands in an output register; a new input beat is accepted
// while it waits. If the receiver stalls with a result still held, the next
// item finishes its scan and then holds until the register frees.
// The tolerance register (reset 50) is written by cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset empties the member table and cluster counts; memory contents are
// not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_proximity_clusterer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [ipc_pkg::POS_W-1:0]  cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire ipc_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output ipc_pkg::out_item_t              out_data
);

	ipc_pkg::state_t             state_q;
	ipc_pkg::state_t             state_d;
	ipc_pkg::in_item_t           item_q;
	logic [ipc_pkg::POS_W-1:0]   tol_q;
	logic [ipc_pkg::CNT_W-1:0]   stored_q;
	logic [ipc_pkg::CNT_W-1:0]   clusters_q;
	logic [ipc_pkg::SIZE_W-1:0]  cnt_mem_q [ipc_pkg::MAX_ENTRIES];
	logic [ipc_pkg::SIZE_W-1:0]  cnt_rd_q;
	logic                        out_valid_q;
	ipc_pkg::out_item_t          out_data_q;
	ipc_pkg::match_cmd_t         cmd;
	ipc_pkg::match_sts_t         sts;
	logic                        accept;
	logic                        fire;
	logic                        full;
	ipc_pkg::out_item_t          res;

	assign accept = in_valid && in_ready;
	assign full   = (stored_q == ipc_pkg::TABLE_FULL);
	assign fire   = (state_q == ipc_pkg::ST_FINISH) && (!out_valid_q || out_ready);

	ipc_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (item_q),
		.tol    (tol_q),
		.sts    (sts)
	);

	always_comb begin
		res = '0;
		if (full) begin
			res.table_full = 1'b1;
			if (sts.found) begin
				res.cluster_index = sts.best;
				res.cluster_size  = cnt_rd_q;
			end
		end else if (sts.found) begin
			res.cluster_index = sts.best;
			res.cluster_size  = cnt_rd_q + ipc_pkg::SIZE_W'(1);
		end else begin
			res.cluster_index = clusters_q[ipc_pkg::CLU_W-1:0];
			res.opened_new    = 1'b1;
			res.cluster_size  = ipc_pkg::SIZE_W'(1);
		end
	end

	always_comb begin
		state_d              = state_q;
		in_ready             = 1'b0;
		cmd                  = '0;
		cmd.scan_len         = stored_q;
		cmd.wr_addr          = stored_q[ipc_pkg::ADDR_W-1:0];
		cmd.wr_data.chrom     = item_q.chrom_id;
		cmd.wr_data.start_pos = item_q.start_pos;
		cmd.wr_data.end_pos   = item_q.end_pos;
		cmd.wr_data.cluster   = res.cluster_index;
		case (state_q)
			ipc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ipc_pkg::ST_START;
				end
			end
			ipc_pkg::ST_START: begin
				cmd.scan_start = 1'b1;
				state_d        = ipc_pkg::ST_SCAN;
			end
			ipc_pkg::ST_SCAN: begin
				if (sts.idle) begin
					state_d = ipc_pkg::ST_CNT_RD;
				end
			end
			ipc_pkg::ST_CNT_RD: begin
				state_d = ipc_pkg::ST_FINISH;
			end
			ipc_pkg::ST_FINISH: begin
				if (fire) begin
					cmd.wr_en = !full;
					state_d   = ipc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ipc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == ipc_pkg::ST_CNT_RD) begin
			cnt_rd_q <= cnt_mem_q[sts.best];
		end
		if (fire && !full) begin
			cnt_mem_q[res.cluster_index] <= res.cluster_size;
		end
		if (fire) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= ipc_pkg::TOL_RESET;
			stored_q    <= '0;
			clusters_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end
			if (accept && in_data.set_begin) begin
				stored_q   <= '0;
				clusters_q <= '0;
			end else if (fire && !full) begin
				stored_q <= stored_q + ipc_pkg::CNT_W'(1);
				if (!sts.found) begin
					clusters_q <= clusters_q + ipc_pkg::CNT_W'(1);
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= ipc_pkg::TABLE_FULL)
		else $error("member count beyond table depth");

	a_clusters_bound: assert property (@(posedge clk) disable iff (!arst_n)
		clusters_q <= stored_q)
		else $error("more clusters than stored members");

	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> sts.idle)
		else $error("input taken while compare unit busy");

	a_store_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !full) |=> (stored_q == $past(stored_q) + ipc_pkg::CNT_W'(1)))
		else $error("member count did not advance on store");
`endif

endmodule

`default_nettype wire
